### hw/rtl/spm_pkg.sv
// Shared constants and types for the segment pair closest point pipeline.
// No dependencies; imported by every module of the block.
`default_nettype none

package spm_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int STATUS_W        = 2;
    localparam int MUL_LAT         = 2;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_RANGE = 2'd1;
    localparam status_t ST_DEGEN = 2'd2;

endpackage

`default_nettype wire

### hw/rtl/segment_pair_closest_points.sv
// Closest points between two 3D segments, fully pipelined.
// Depends on spm_pkg, spm_mul, spm_div, spm_sqrt and spm_delay.
//
// The input channel (s_valid/s_ready) takes one word of four points: segment A
// from a0 to a1 and segment B from b0 to b1, signed fixed point coordinates.
// The result channel (m_valid/m_ready) returns one word per input word, in order:
// status, the two segment parameters, both closest points, their distance and
// the cosine between a0 minus near_a and b0 minus near_b.
// One word can enter every cycle while the output is not stalled. The path runs
// through the Gram terms and their products, the FRAC_BITS+1 step parameter
// divider and the four point and dot product stages, then the cosine path (a
// multiply, a 2*FRAC_BITS+1 step divider and a FRAC_BITS+1 step root) and the
// distance root (COORD_WIDTH+4 steps) side by side, whichever is longer setting
// the depth, and ends in the output register.
// All stages advance together; when m_valid is high and m_ready low the whole
// pipeline holds and s_ready is low, so no word is lost or repeated.
// Reset clears all valid bits; the datapath registers are not reset.
`default_nettype none

module segment_pair_closest_points
    import spm_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [COORD_WIDTH-1:0] s_a0_x,
    input  wire logic signed [COORD_WIDTH-1:0] s_a0_y,
    input  wire logic signed [COORD_WIDTH-1:0] s_a0_z,
    input  wire logic signed [COORD_WIDTH-1:0] s_a1_x,
    input  wire logic signed [COORD_WIDTH-1:0] s_a1_y,
    input  wire logic signed [COORD_WIDTH-1:0] s_a1_z,
    input  wire logic signed [COORD_WIDTH-1:0] s_b0_x,
    input  wire logic signed [COORD_WIDTH-1:0] s_b0_y,
    input  wire logic signed [COORD_WIDTH-1:0] s_b0_z,
    input  wire logic signed [COORD_WIDTH-1:0] s_b1_x,
    input  wire logic signed [COORD_WIDTH-1:0] s_b1_y,
    input  wire logic signed [COORD_WIDTH-1:0] s_b1_z,

    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [STATUS_W-1:0]                m_status,
    output logic [FRAC_BITS:0]                 m_frac_a,
    output logic [FRAC_BITS:0]                 m_frac_b,
    output logic signed [COORD_WIDTH-1:0]      m_near_a_x,
    output logic signed [COORD_WIDTH-1:0]      m_near_a_y,
    output logic signed [COORD_WIDTH-1:0]      m_near_a_z,
    output logic signed [COORD_WIDTH-1:0]      m_near_b_x,
    output logic signed [COORD_WIDTH-1:0]      m_near_b_y,
    output logic signed [COORD_WIDTH-1:0]      m_near_b_z,
    output logic [COORD_WIDTH:0]               m_gap,
    output logic signed [FRAC_BITS+1:0]        m_cos_between
);

    localparam int CW   = COORD_WIDTH;
    localparam int FB   = FRAC_BITS;
    localparam int DW   = CW + 1;
    localparam int QW2  = 2 * DW;
    localparam int GW   = 2 * DW + 2;
    localparam int PW   = 2 * GW;
    localparam int NW   = PW + 1;
    localparam int LW   = FB + 1;
    localparam int XPW  = DW + LW + 1;
    localparam int EW   = CW + 3;
    localparam int SW   = 2 * EW + 2;
    localparam int RWG  = (SW + 1) / 2;
    localparam int CNW  = 2 * SW;
    localparam int YW   = 2 * FB + 1;
    localparam int RWC  = FB + 1;
    localparam int OW   = FB + 2;

    localparam int T_G   = 6;
    localparam int T_ST  = T_G + 1;
    localparam int T_LA  = T_G + LW;
    localparam int T_E   = T_LA + 2;
    localparam int T_SQ  = T_LA + 4;
    localparam int T_GAP = T_SQ + RWG;
    localparam int T_C   = T_SQ + MUL_LAT + YW + RWC;
    localparam int T_F   = (T_C > T_GAP) ? T_C : T_GAP;

    localparam logic [LW-1:0]        FRAC_ONE = {1'b1, {FB{1'b0}}};
    localparam logic signed [OW-1:0] COS_ONE  = {2'b01, {FB{1'b0}}};
    localparam logic signed [OW-1:0] COS_NEG  = {2'b11, {FB{1'b0}}};

    typedef struct packed {
        logic [2:0][DW-1:0] d1;
        logic [2:0][DW-1:0] d2;
        logic [2:0][CW-1:0] p0;
        logic [2:0][CW-1:0] p2;
    } geo_t;

    typedef struct packed {
        logic [2:0][CW-1:0] e;
        logic [2:0][CW-1:0] f;
    } near_t;

    typedef struct packed {
        logic cz;
        logic neg;
    } cflag_t;

    logic en;
    logic accept;

    logic [T_F:1] vld_reg;
    logic         m_valid_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;
    assign accept  = s_valid && en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[T_F-1:1], accept};
            m_valid_reg <= vld_reg[T_F];
        end
    end

    assign m_valid = m_valid_reg;

    // Stage 1: edge and offset vectors.
    logic signed [CW-1:0] pa0 [3];
    logic signed [CW-1:0] pa1 [3];
    logic signed [CW-1:0] pb0 [3];
    logic signed [CW-1:0] pb1 [3];

    assign pa0[0] = s_a0_x;
    assign pa0[1] = s_a0_y;
    assign pa0[2] = s_a0_z;
    assign pa1[0] = s_a1_x;
    assign pa1[1] = s_a1_y;
    assign pa1[2] = s_a1_z;
    assign pb0[0] = s_b0_x;
    assign pb0[1] = s_b0_y;
    assign pb0[2] = s_b0_z;
    assign pb1[0] = s_b1_x;
    assign pb1[1] = s_b1_y;
    assign pb1[2] = s_b1_z;

    geo_t               geo_reg;
    logic [2:0][DW-1:0] w_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                geo_reg.d1[k] <= DW'(pa1[k]) - DW'(pa0[k]);
                geo_reg.d2[k] <= DW'(pb1[k]) - DW'(pb0[k]);
                geo_reg.p0[k] <= pa0[k];
                geo_reg.p2[k] <= pb0[k];
                w_reg[k]      <= DW'(pb0[k]) - DW'(pa0[k]);
            end
        end
    end

    // Stage 2: fifteen coordinate products; stage 3: the Gram terms.
    logic signed [QW2-1:0] m11_reg [3];
    logic signed [QW2-1:0] m12_reg [3];
    logic signed [QW2-1:0] m22_reg [3];
    logic signed [QW2-1:0] m1w_reg [3];
    logic signed [QW2-1:0] m2w_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                m11_reg[k] <= $signed(geo_reg.d1[k]) * $signed(geo_reg.d1[k]);
                m12_reg[k] <= $signed(geo_reg.d1[k]) * $signed(geo_reg.d2[k]);
                m22_reg[k] <= $signed(geo_reg.d2[k]) * $signed(geo_reg.d2[k]);
                m1w_reg[k] <= $signed(geo_reg.d1[k]) * $signed(w_reg[k]);
                m2w_reg[k] <= $signed(geo_reg.d2[k]) * $signed(w_reg[k]);
            end
        end
    end

    logic signed [GW-1:0] ga_reg;
    logic signed [GW-1:0] gb_reg;
    logic signed [GW-1:0] gc_reg;
    logic signed [GW-1:0] gd_reg;
    logic signed [GW-1:0] ge_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            ga_reg <= GW'(m11_reg[0]) + GW'(m11_reg[1]) + GW'(m11_reg[2]);
            gb_reg <= GW'(m12_reg[0]) + GW'(m12_reg[1]) + GW'(m12_reg[2]);
            gc_reg <= GW'(m22_reg[0]) + GW'(m22_reg[1]) + GW'(m22_reg[2]);
            gd_reg <= GW'(m1w_reg[0]) + GW'(m1w_reg[1]) + GW'(m1w_reg[2]);
            ge_reg <= GW'(m2w_reg[0]) + GW'(m2w_reg[1]) + GW'(m2w_reg[2]);
        end
    end

    // Stages 4 and 5: products of Gram terms; stage 6: determinant and numerators.
    logic signed [PW-1:0] p_ac;
    logic signed [PW-1:0] p_bb;
    logic signed [PW-1:0] p_cd;
    logic signed [PW-1:0] p_be;
    logic signed [PW-1:0] p_bd;
    logic signed [PW-1:0] p_ae;

    spm_mul #(.AW(GW), .BW(GW)) u_mul_ac (.aclk(aclk), .en(en), .a(ga_reg), .b(gc_reg), .p(p_ac));
    spm_mul #(.AW(GW), .BW(GW)) u_mul_bb (.aclk(aclk), .en(en), .a(gb_reg), .b(gb_reg), .p(p_bb));
    spm_mul #(.AW(GW), .BW(GW)) u_mul_cd (.aclk(aclk), .en(en), .a(gc_reg), .b(gd_reg), .p(p_cd));
    spm_mul #(.AW(GW), .BW(GW)) u_mul_be (.aclk(aclk), .en(en), .a(gb_reg), .b(ge_reg), .p(p_be));
    spm_mul #(.AW(GW), .BW(GW)) u_mul_bd (.aclk(aclk), .en(en), .a(gb_reg), .b(gd_reg), .p(p_bd));
    spm_mul #(.AW(GW), .BW(GW)) u_mul_ae (.aclk(aclk), .en(en), .a(ga_reg), .b(ge_reg), .p(p_ae));

    logic signed [NW-1:0] den_reg;
    logic signed [NW-1:0] nla_reg;
    logic signed [NW-1:0] nmu_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg <= NW'(p_ac) - NW'(p_bb);
            nla_reg <= NW'(p_cd) - NW'(p_be);
            nmu_reg <= NW'(p_bd) - NW'(p_ae);
        end
    end

    // Stage 7: classification of the parameters.
    status_t st_reg;
    logic    deg;
    logic    oor;

    assign deg = den_reg[NW-1] || (den_reg == '0);
    assign oor = nla_reg[NW-1] || (nla_reg > den_reg) || nmu_reg[NW-1] || (nmu_reg > den_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            if (deg) begin
                st_reg <= ST_DEGEN;
            end else if (oor) begin
                st_reg <= ST_RANGE;
            end else begin
                st_reg <= ST_OK;
            end
        end
    end

    // Parameter dividers.
    logic [LW-1:0] la;
    logic [LW-1:0] mu;

    spm_div #(.NW(NW), .QW(LW)) u_div_la (
        .aclk(aclk), .en(en), .num(nla_reg), .den(den_reg), .quo(la)
    );
    spm_div #(.NW(NW), .QW(LW)) u_div_mu (
        .aclk(aclk), .en(en), .num(nmu_reg), .den(den_reg), .quo(mu)
    );

    geo_t geo_d;

    spm_delay #(.W($bits(geo_t)), .N(T_LA - 1)) u_dly_geo (
        .aclk(aclk), .en(en), .din(geo_reg), .dout(geo_d)
    );

    // Closest points and the vectors from the segment starts.
    logic signed [XPW-1:0] pra_reg [3];
    logic signed [XPW-1:0] prb_reg [3];
    logic [2:0][CW-1:0]    p0_q_reg;
    logic [2:0][CW-1:0]    p2_q_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                pra_reg[k] <= $signed(geo_d.d1[k]) * $signed({1'b0, la});
                prb_reg[k] <= $signed(geo_d.d2[k]) * $signed({1'b0, mu});
            end
            p0_q_reg <= geo_d.p0;
            p2_q_reg <= geo_d.p2;
        end
    end

    logic signed [EW-1:0] ea_reg [3];
    logic signed [EW-1:0] fb_reg [3];
    logic signed [EW-1:0] g_reg  [3];
    near_t                near_reg;

    for (genvar k = 0; k < 3; k++) begin : g_pts
        logic signed [XPW-1:0] sha;
        logic signed [XPW-1:0] shb;
        logic signed [EW-1:0]  e_n;
        logic signed [EW-1:0]  f_n;

        assign sha = pra_reg[k] >>> FB;
        assign shb = prb_reg[k] >>> FB;
        assign e_n = EW'($signed(p0_q_reg[k])) + EW'(sha);
        assign f_n = EW'($signed(p2_q_reg[k])) + EW'(shb);

        always_ff @(posedge aclk) begin
            if (en) begin
                ea_reg[k]     <= '0 - EW'(sha);
                fb_reg[k]     <= '0 - EW'(shb);
                g_reg[k]      <= e_n - f_n;
                near_reg.e[k] <= e_n[CW-1:0];
                near_reg.f[k] <= f_n[CW-1:0];
            end
        end
    end

    logic signed [2*EW-1:0] sgg_reg [3];
    logic signed [2*EW-1:0] saa_reg [3];
    logic signed [2*EW-1:0] sbb_reg [3];
    logic signed [2*EW-1:0] sab_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                sgg_reg[k] <= g_reg[k] * g_reg[k];
                saa_reg[k] <= ea_reg[k] * ea_reg[k];
                sbb_reg[k] <= fb_reg[k] * fb_reg[k];
                sab_reg[k] <= ea_reg[k] * fb_reg[k];
            end
        end
    end

    logic signed [SW-1:0] sq_reg;
    logic signed [SW-1:0] aa_reg;
    logic signed [SW-1:0] bb_reg;
    logic signed [SW-1:0] dt_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg <= SW'(sgg_reg[0]) + SW'(sgg_reg[1]) + SW'(sgg_reg[2]);
            aa_reg <= SW'(saa_reg[0]) + SW'(saa_reg[1]) + SW'(saa_reg[2]);
            bb_reg <= SW'(sbb_reg[0]) + SW'(sbb_reg[1]) + SW'(sbb_reg[2]);
            dt_reg <= SW'(sab_reg[0]) + SW'(sab_reg[1]) + SW'(sab_reg[2]);
        end
    end

    // Distance root.
    logic [RWG-1:0] gap_root;

    spm_sqrt #(.IW(SW), .RW(RWG)) u_sqrt_gap (
        .aclk(aclk), .en(en), .x(sq_reg), .root(gap_root)
    );

    // Cosine: floor(sqrt(dt^2 * 2^(2*FB) / (aa*bb))), sign of dt applied at the end.
    logic signed [CNW-1:0] dt2;
    logic signed [CNW-1:0] aabb;
    logic [YW-1:0]         cos2;
    logic [RWC-1:0]        cos_root;

    spm_mul #(.AW(SW), .BW(SW)) u_mul_dt2 (.aclk(aclk), .en(en), .a(dt_reg), .b(dt_reg), .p(dt2));
    spm_mul #(.AW(SW), .BW(SW)) u_mul_ab  (.aclk(aclk), .en(en), .a(aa_reg), .b(bb_reg), .p(aabb));

    spm_div #(.NW(CNW), .QW(YW)) u_div_cos (
        .aclk(aclk), .en(en), .num(dt2), .den(aabb), .quo(cos2)
    );

    spm_sqrt #(.IW(YW), .RW(RWC)) u_sqrt_cos (
        .aclk(aclk), .en(en), .x(cos2), .root(cos_root)
    );

    // Alignment of side results with the final stage.
    status_t        st_d;
    logic [LW-1:0]  la_d;
    logic [LW-1:0]  mu_d;
    near_t          near_d;
    logic [RWG-1:0] gap_d;
    logic [RWC-1:0] cos_d;
    cflag_t         cflag;
    cflag_t         cflag_d;

    assign cflag.cz  = (aa_reg == '0) || (bb_reg == '0);
    assign cflag.neg = dt_reg[SW-1];

    spm_delay #(.W(STATUS_W), .N(T_F - T_ST)) u_dly_st (
        .aclk(aclk), .en(en), .din(st_reg), .dout(st_d)
    );
    spm_delay #(.W(LW), .N(T_F - T_LA)) u_dly_la (
        .aclk(aclk), .en(en), .din(la), .dout(la_d)
    );
    spm_delay #(.W(LW), .N(T_F - T_LA)) u_dly_mu (
        .aclk(aclk), .en(en), .din(mu), .dout(mu_d)
    );
    spm_delay #(.W($bits(near_t)), .N(T_F - T_E)) u_dly_near (
        .aclk(aclk), .en(en), .din(near_reg), .dout(near_d)
    );
    spm_delay #(.W(RWG), .N(T_F - T_GAP)) u_dly_gap (
        .aclk(aclk), .en(en), .din(gap_root), .dout(gap_d)
    );
    spm_delay #(.W(RWC), .N(T_F - T_C)) u_dly_cos (
        .aclk(aclk), .en(en), .din(cos_root), .dout(cos_d)
    );
    spm_delay #(.W($bits(cflag_t)), .N(T_F - T_SQ)) u_dly_cf (
        .aclk(aclk), .en(en), .din(cflag), .dout(cflag_d)
    );

    // Output register.
    logic                 gap_sat;
    logic [CW:0]          gap_fin;
    logic signed [OW-1:0] cos_mag;
    logic signed [OW-1:0] cos_fin;

    assign gap_sat = |gap_d[RWG-1:CW+1];
    assign gap_fin = gap_sat ? '1 : gap_d[CW:0];
    assign cos_mag = $signed({1'b0, cos_d});
    assign cos_fin = cflag_d.neg ? ('0 - cos_mag) : cos_mag;

    status_t              st_out_reg;
    logic [LW-1:0]        fa_reg;
    logic [LW-1:0]        fbv_reg;
    near_t                near_out_reg;
    logic [CW:0]          gap_reg;
    logic signed [OW-1:0] cos_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (st_d != ST_OK) begin
                st_out_reg   <= st_d;
                fa_reg       <= '0;
                fbv_reg      <= '0;
                near_out_reg <= '0;
                gap_reg      <= '0;
                cos_reg      <= '0;
            end else begin
                st_out_reg   <= cflag_d.cz ? ST_DEGEN : ST_OK;
                fa_reg       <= la_d;
                fbv_reg      <= mu_d;
                near_out_reg <= near_d;
                gap_reg      <= gap_fin;
                cos_reg      <= cflag_d.cz ? '0 : cos_fin;
            end
        end
    end

    assign m_status      = st_out_reg;
    assign m_frac_a      = fa_reg;
    assign m_frac_b      = fbv_reg;
    assign m_near_a_x    = $signed(near_out_reg.e[0]);
    assign m_near_a_y    = $signed(near_out_reg.e[1]);
    assign m_near_a_z    = $signed(near_out_reg.e[2]);
    assign m_near_b_x    = $signed(near_out_reg.f[0]);
    assign m_near_b_y    = $signed(near_out_reg.f[1]);
    assign m_near_b_z    = $signed(near_out_reg.f[2]);
    assign m_gap         = gap_reg;
    assign m_cos_between = cos_reg;

    a_range_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_RANGE) |-> (m_gap == '0) && (m_frac_a == '0)
            && (m_frac_b == '0))
        else $error("out of range word carries nonzero fields");

    a_frac_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_OK) |-> (m_frac_a <= FRAC_ONE) && (m_frac_b <= FRAC_ONE))
        else $error("segment parameter above one");

    a_cos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_cos_between <= COS_ONE) && (m_cos_between >= COS_NEG))
        else $error("cosine outside of minus one to one");

    a_ready_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");

endmodule

`default_nettype wire

### hw/rtl/spm_mul.sv
// Two stage signed multiplier built from four half width partial products.
// Depends on spm_pkg only for the house import.
`default_nettype none

module spm_mul
    import spm_pkg::*;
#(
    parameter int AW = 68,
    parameter int BW = 68
) (
    input  wire logic                     aclk,
    input  wire logic                     en,
    input  wire logic signed [AW-1:0]     a,
    input  wire logic signed [BW-1:0]     b,
    output logic signed [AW+BW-1:0]       p
);

    localparam int LA = AW / 2;
    localparam int HA = AW - LA;
    localparam int LB = BW / 2;
    localparam int HB = BW - LB;
    localparam int PW = AW + BW;

    logic signed [HA+HB-1:0] hh_reg;
    logic signed [HA+LB:0]   hl_reg;
    logic signed [LA+HB:0]   lh_reg;
    logic [LA+LB-1:0]        ll_reg;
    logic signed [PW-1:0]    hh_x;
    logic signed [PW-1:0]    hl_x;
    logic signed [PW-1:0]    lh_x;
    logic [PW-1:0]           ll_x;
    logic [PW-1:0]           p_next;
    logic [PW-1:0]           p_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            hh_reg <= $signed(a[AW-1:LA]) * $signed(b[BW-1:LB]);
            hl_reg <= $signed(a[AW-1:LA]) * $signed({1'b0, b[LB-1:0]});
            lh_reg <= $signed({1'b0, a[LA-1:0]}) * $signed(b[BW-1:LB]);
            ll_reg <= a[LA-1:0] * b[LB-1:0];
        end
    end

    assign hh_x = hh_reg;
    assign hl_x = hl_reg;
    assign lh_x = lh_reg;
    assign ll_x = PW'(ll_reg);

    assign p_next = (hh_x <<< (LA + LB)) + (hl_x <<< LA) + (lh_x <<< LB) + ll_x;

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= p_next;
        end
    end

    assign p = $signed(p_reg);

endmodule

`default_nettype wire

### hw/rtl/spm_div.sv
// Pipelined restoring divider: one quotient bit per stage, floor(num*2^(QW-1)/den).
// Expects num <= den; depends on spm_pkg for the house import.
`default_nettype none

module spm_div
    import spm_pkg::*;
#(
    parameter int NW = 137,
    parameter int QW = 17
) (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire logic [NW-1:0] num,
    input  wire logic [NW-1:0] den,
    output logic [QW-1:0]      quo
);

    logic [NW-1:0] rem_reg [QW];
    logic [NW-1:0] den_reg [QW];
    logic [QW-1:0] q_reg   [QW];

    for (genvar i = 0; i < QW; i++) begin : g_step
        logic [NW:0]   t;
        logic [NW-1:0] dp;
        logic [QW-1:0] qp;
        logic [NW:0]   diff;
        logic          ge;

        if (i == 0) begin : g_first
            assign t  = {1'b0, num};
            assign dp = den;
            assign qp = '0;
        end else begin : g_next
            assign t  = {rem_reg[i-1], 1'b0};
            assign dp = den_reg[i-1];
            assign qp = q_reg[i-1];
        end

        assign ge   = t >= {1'b0, dp};
        assign diff = t - {1'b0, dp};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i] <= ge ? diff[NW-1:0] : t[NW-1:0];
                den_reg[i] <= dp;
                q_reg[i]   <= {qp[QW-2:0], ge};
            end
        end
    end

    assign quo = q_reg[QW-1];

endmodule

`default_nettype wire

### hw/rtl/spm_sqrt.sv
// Pipelined integer square root: one root bit per stage, floor(sqrt(x)).
// Depends on spm_pkg for the house import.
`default_nettype none

module spm_sqrt
    import spm_pkg::*;
#(
    parameter int IW = 72,
    parameter int RW = 36
) (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire logic [IW-1:0] x,
    output logic [RW-1:0]      root
);

    localparam int XW = 2 * RW;
    localparam int TW = XW + 1;

    logic [XW-1:0] rem_reg [RW];
    logic [RW-1:0] r_reg   [RW];

    for (genvar i = 0; i < RW; i++) begin : g_step
        localparam int B = RW - 1 - i;
        logic [XW-1:0] rp;
        logic [RW-1:0] qp;
        logic [TW-1:0] term;
        logic          ge;

        if (i == 0) begin : g_first
            assign rp = XW'(x);
            assign qp = '0;
        end else begin : g_next
            assign rp = rem_reg[i-1];
            assign qp = r_reg[i-1];
        end

        assign term = (TW'(qp) << (B + 1)) | (TW'(1) << (2 * B));
        assign ge   = {1'b0, rp} >= term;

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i] <= ge ? XW'({1'b0, rp} - term) : rp;
                r_reg[i]   <= ge ? (qp | (RW'(1) << B)) : qp;
            end
        end
    end

    assign root = r_reg[RW-1];

endmodule

`default_nettype wire

### hw/rtl/spm_delay.sv
// Enabled shift register that keeps side data aligned with the datapath stages.
// Depends on spm_pkg for the house import.
`default_nettype none

module spm_delay
    import spm_pkg::*;
#(
    parameter int W = 8,
    parameter int N = 1
) (
    input  wire logic         aclk,
    input  wire logic         en,
    input  wire logic [W-1:0] din,
    output logic [W-1:0]      dout
);

    if (N == 0) begin : g_none
        assign dout = din;
    end else begin : g_line
        logic [W-1:0] line_reg [N];

        always_ff @(posedge aclk) begin
            if (en) begin
                line_reg[0] <= din;
                for (int i = 1; i < N; i++) begin
                    line_reg[i] <= line_reg[i-1];
                end
            end
        end

        assign dout = line_reg[N-1];
    end

endmodule

`default_nettype wire

### verif/tb.sv
// Self-checking testbench for segment_pair_closest_points: a queue-fed driver,
// a monitor and a wide-integer predictor of the closest points on two segments.
// Depends on spm_pkg and the RTL of the block.
module tb;
    import spm_pkg::*;

    localparam int CW = 32;
    localparam int FB = 16;
    localparam int CYCLE_LIMIT = 1000000;

    typedef logic signed [255:0] wide_t;
    typedef longint vec_t[3];

    typedef struct packed {
        logic [11:0][CW-1:0] c;
    } seg_pair_t;

    typedef struct packed {
        status_t             status;
        logic [FB:0]         frac_a;
        logic [FB:0]         frac_b;
        logic [2:0][CW-1:0]  near_a;
        logic [2:0][CW-1:0]  near_b;
        logic [CW:0]         gap;
        logic [FB+1:0]       cosv;
    } closest_t;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic m_valid;
    logic m_ready;
    seg_pair_t s_word;
    closest_t got;

    seg_pair_t pending_words[$];
    closest_t expected_closest[$];
    int errors;
    int send_idle;
    int recv_idle;
    int cycles;
    logic took;

    segment_pair_closest_points u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_a0_x(s_word.c[0]), .s_a0_y(s_word.c[1]), .s_a0_z(s_word.c[2]),
        .s_a1_x(s_word.c[3]), .s_a1_y(s_word.c[4]), .s_a1_z(s_word.c[5]),
        .s_b0_x(s_word.c[6]), .s_b0_y(s_word.c[7]), .s_b0_z(s_word.c[8]),
        .s_b1_x(s_word.c[9]), .s_b1_y(s_word.c[10]), .s_b1_z(s_word.c[11]),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_status(got.status), .m_frac_a(got.frac_a), .m_frac_b(got.frac_b),
        .m_near_a_x(got.near_a[0]), .m_near_a_y(got.near_a[1]),
        .m_near_a_z(got.near_a[2]),
        .m_near_b_x(got.near_b[0]), .m_near_b_y(got.near_b[1]),
        .m_near_b_z(got.near_b[2]),
        .m_gap(got.gap), .m_cos_between(got.cosv)
    );

    function automatic wide_t dot(vec_t u, vec_t v);
        wide_t s;
        s = 0;
        for (int k = 0; k < 3; k++) s = s + wide_t'(u[k]) * wide_t'(v[k]);
        return s;
    endfunction

    // Largest r below 2^(hi+1) with r*r*m <= lim.
    function automatic wide_t root_below(wide_t lim, wide_t m, int hi);
        wide_t r;
        wide_t cand;
        r = 0;
        for (int bit_i = hi; bit_i >= 0; bit_i--) begin
            cand = r | (wide_t'(1) <<< bit_i);
            if (cand * cand * m <= lim) r = cand;
        end
        return r;
    endfunction

    function automatic closest_t predict_closest(seg_pair_t sp);
        closest_t res;
        longint p[4][3];
        vec_t d1, d2, w, e, f, ea, fb, g;
        wide_t a, b, c, dd, ee, den, nla, nmu, la, mu, sq, gw, aa, bb, dt, q;
        res = '0;
        for (int i = 0; i < 12; i++) p[i/3][i%3] = longint'(signed'(sp.c[i]));
        for (int k = 0; k < 3; k++) begin
            d1[k] = p[1][k] - p[0][k];
            d2[k] = p[3][k] - p[2][k];
            w[k]  = p[2][k] - p[0][k];
        end
        a = dot(d1, d1); b = dot(d1, d2); c = dot(d2, d2);
        dd = dot(d1, w); ee = dot(d2, w);
        den = a * c - b * b;
        nla = c * dd - b * ee;
        nmu = b * dd - a * ee;
        if (den <= 0) begin
            res.status = ST_DEGEN;
            return res;
        end
        if (nla < 0 || nla > den || nmu < 0 || nmu > den) begin
            res.status = ST_RANGE;
            return res;
        end
        la = (nla <<< FB) / den;
        mu = (nmu <<< FB) / den;
        for (int k = 0; k < 3; k++) begin
            e[k] = p[0][k] + longint'((wide_t'(d1[k]) * la) >>> FB);
            f[k] = p[2][k] + longint'((wide_t'(d2[k]) * mu) >>> FB);
            g[k] = e[k] - f[k];
            ea[k] = p[0][k] - e[k];
            fb[k] = p[2][k] - f[k];
            res.near_a[k] = e[k][CW-1:0];
            res.near_b[k] = f[k][CW-1:0];
        end
        sq = dot(g, g);
        gw = root_below(sq, 1, 62);
        if (gw > wide_t'({(CW+1){1'b1}})) gw = wide_t'({(CW+1){1'b1}});
        res.status = ST_OK;
        res.frac_a = la[FB:0];
        res.frac_b = mu[FB:0];
        res.gap = gw[CW:0];
        aa = dot(ea, ea);
        bb = dot(fb, fb);
        if (aa == 0 || bb == 0) begin
            res.status = ST_DEGEN;
            return res;
        end
        dt = dot(ea, fb);
        q = root_below((dt * dt) <<< (2 * FB), aa * bb, FB);
        if (dt < 0) q = -q;
        res.cosv = q[FB+1:0];
        return res;
    endfunction

    task automatic report(string name, longint unsigned want, longint unsigned have);
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, have);
    endtask

    task automatic add_word(seg_pair_t sp);
        pending_words.insert(pending_words.size(), sp);
    endtask

    task automatic add_expected(closest_t res);
        expected_closest.insert(expected_closest.size(), res);
    endtask

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Driver: a new word is presented once the current one has been taken.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || took) begin
                if (pending_words.size() > 0 && $urandom_range(99) >= send_idle) begin
                    s_word <= pending_words.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Monitor: predicts on acceptance and checks each returned word.
    always @(posedge aclk) begin
        closest_t want;
        took <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready)
            add_expected(predict_closest(s_word));
        if (aresetn && m_valid && m_ready) begin
            if (expected_closest.size() == 0) begin
                errors++;
                $display("%0t: unexpected word, expected none, actual status %0d",
                         $time, got.status);
            end else begin
                want = expected_closest.pop_front();
                if (want.status !== got.status) report("status", want.status, got.status);
                if (want.frac_a !== got.frac_a) report("frac_a", want.frac_a, got.frac_a);
                if (want.frac_b !== got.frac_b) report("frac_b", want.frac_b, got.frac_b);
                for (int k = 0; k < 3; k++) begin
                    if (want.near_a[k] !== got.near_a[k])
                        report($sformatf("near_a[%0d]", k), want.near_a[k], got.near_a[k]);
                    if (want.near_b[k] !== got.near_b[k])
                        report($sformatf("near_b[%0d]", k), want.near_b[k], got.near_b[k]);
                end
                if (want.gap !== got.gap) report("gap", want.gap, got.gap);
                if (want.cosv !== got.cosv) report("cos_between", want.cosv, got.cosv);
            end
        end
    end

    function automatic seg_pair_t from_points(vec_t a0, vec_t a1, vec_t b0, vec_t b1);
        seg_pair_t sp;
        for (int k = 0; k < 3; k++) begin
            sp.c[k] = a0[k][CW-1:0];
            sp.c[3+k] = a1[k][CW-1:0];
            sp.c[6+k] = b0[k][CW-1:0];
            sp.c[9+k] = b1[k][CW-1:0];
        end
        return sp;
    endfunction

    function automatic longint spread(int sh);
        return longint'($urandom_range(0, (1 << (sh + 1)) - 1)) - (longint'(1) << sh);
    endfunction

    // Segment B is laid through a point near segment A, so most words land inside.
    function automatic seg_pair_t crossing_pair();
        vec_t a0, a1, b0, b1;
        longint q, r;
        int sh, nsh, t, k8;
        sh = $urandom_range(4, 27);
        nsh = $urandom_range(0, sh);
        t = $urandom_range(0, 256);
        k8 = $urandom_range(0, 256);
        for (int k = 0; k < 3; k++) begin
            a0[k] = spread(sh);
            a1[k] = spread(sh);
            q = a0[k] + (((a1[k] - a0[k]) * t) >>> 8);
            if ($urandom_range(3) != 0) q = q + spread(nsh);
            r = spread(sh);
            b0[k] = q + ((r * k8) >>> 8);
            b1[k] = q - ((r * (256 - k8)) >>> 8);
        end
        return from_points(a0, a1, b0, b1);
    endfunction

    function automatic seg_pair_t noise_pair();
        seg_pair_t sp;
        int sh;
        sh = $urandom_range(0, 1) ? 31 : $urandom_range(1, 22);
        for (int i = 0; i < 12; i++)
            sp.c[i] = (sh == 31) ? CW'($urandom) : CW'(spread(sh));
        return sp;
    endfunction

    task automatic add_directed();
        seg_pair_t sp;
        vec_t a0, a1, b0, b1;
        longint one;
        one = 64'sd1 << FB;
        sp = '0;
        add_word(sp);
        sp.c = {12{32'h7fffffff}};
        add_word(sp);
        sp.c = {12{32'h80000000}};
        add_word(sp);
        sp.c = {{6{32'h80000000}}, {6{32'h7fffffff}}};
        add_word(sp);
        for (int i = 0; i < 12; i++) sp.c[i] = (i % 2) ? 32'h7fffffff : 32'h80000000;
        add_word(sp);
        for (int i = 0; i < 12; i++) sp.c[i] = (i % 5 == 0) ? 32'h80000000 : 32'h7fffffff;
        add_word(sp);
        // Perpendicular segments crossing in their middles.
        a0 = '{-one, 0, 0}; a1 = '{one, 0, 0}; b0 = '{0, -one, 0}; b1 = '{0, one, 0};
        add_word(from_points(a0, a1, b0, b1));
        // Skew segments one unit apart.
        b0 = '{0, -one, one}; b1 = '{0, one, one};
        add_word(from_points(a0, a1, b0, b1));
        // Crossing at the start of segment A.
        a0 = '{0, 0, 0}; a1 = '{one, 0, 0}; b0 = '{0, -one, 0}; b1 = '{0, one, 0};
        add_word(from_points(a0, a1, b0, b1));
        // Crossing at the start of segment B.
        a0 = '{-one, 0, 0}; a1 = '{one, 0, 0}; b0 = '{0, 0, 0}; b1 = '{0, one, 0};
        add_word(from_points(a0, a1, b0, b1));
        // Crossing at both ends.
        a0 = '{-one, 0, 0}; a1 = '{0, 0, 0}; b0 = '{0, -one, 0}; b1 = '{0, 0, 0};
        add_word(from_points(a0, a1, b0, b1));
        // Parallel segments.
        a0 = '{0, 0, 0}; a1 = '{one, one, 0}; b0 = '{0, one, 0}; b1 = '{2*one, 3*one, 0};
        b1 = '{one, 2*one, 0};
        add_word(from_points(a0, a1, b0, b1));
        // Zero-length segment B.
        b1 = b0;
        add_word(from_points(a0, a1, b0, b1));
        // Lines cross beyond the end of A, and before the start of B.
        a0 = '{-one, 0, 0}; a1 = '{-one/2, 0, 0}; b0 = '{0, -one, 0}; b1 = '{0, one, 0};
        add_word(from_points(a0, a1, b0, b1));
        a0 = '{-one, 0, 0}; a1 = '{one, 0, 0}; b0 = '{0, one/2, 0}; b1 = '{0, one, 0};
        add_word(from_points(a0, a1, b0, b1));
        // Large segments with a large gap.
        a0 = '{-(64'sd1 << 31), -(64'sd1 << 31), -(64'sd1 << 31)};
        a1 = '{(64'sd1 << 31) - 1, -(64'sd1 << 31), -(64'sd1 << 31)};
        b0 = '{0, (64'sd1 << 31) - 1, -(64'sd1 << 31)};
        b1 = '{0, (64'sd1 << 31) - 1, (64'sd1 << 31) - 1};
        add_word(from_points(a0, a1, b0, b1));
        a0 = '{-one, 3, -7}; a1 = '{one, -5, 2}; b0 = '{1, -one, 9}; b1 = '{-2, one, -3};
        add_word(from_points(a0, a1, b0, b1));
    endtask

    task automatic run_phase(int s_idle, int r_idle, int count);
        int pick;
        send_idle = s_idle;
        recv_idle = r_idle;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            add_word(pick < 75 ? crossing_pair() : noise_pair());
        end
        while (pending_words.size() > 0 || s_valid || expected_closest.size() > 0)
            @(posedge aclk);
    endtask

    initial begin
        errors = 0;
        cycles = 0;
        send_idle = 0;
        recv_idle = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        m_ready = 1'b0;
        s_word = '0;
        took = 1'b0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        add_directed();
        run_phase(0, 0, 480);
        run_phase(78, 0, 480);
        run_phase(0, 78, 480);
        run_phase(34, 34, 490);
        repeat (120) @(posedge aclk);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
